@@ design/bj0s_pkg.sv @@
// Shared constants, types and arithmetic helpers for the J0 power series pipeline.
`default_nettype none

package bj0s_pkg;

    localparam int MAX_TERMS = 20;
    localparam int TERMS_W   = $clog2(MAX_TERMS);
    localparam int X_W       = 32;
    localparam int Q_W       = 53;
    localparam int MAG_W     = 64;
    localparam int THR_W     = 40;
    localparam int FRAC_BITS = 40;
    localparam int HALF_W    = MAG_W / 2;
    localparam int OUT_TDATA_W = 40;

    localparam logic [THR_W-1:0] THR_RESET = 40'd110;
    localparam logic [MAG_W-1:0] ONE_Q40   = 64'h0000_0100_0000_0000;
    localparam logic [MAG_W-1:0] MAG_MAX   = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic signed [MAG_W-1:0] SUM_MAX  = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam logic signed [MAG_W-1:0] SUM_MIN  = 64'sh8000_0000_0000_0000;
    localparam logic signed [MAG_W-1:0] RND_HALF = 64'sh0000_0000_0000_8000;
    localparam logic signed [MAG_W-1:0] RES_HI   = 64'sh0000_8000_0000_0000;
    localparam logic signed [MAG_W-1:0] RES_LO   = 64'shFFFF_8000_0000_0000;
    localparam logic [X_W-1:0] RES_MAX = 32'h7FFF_FFFF;
    localparam logic [X_W-1:0] RES_MIN = 32'h8000_0000;

    // round(2^40 / k^2), index k; entry 0 unused
    localparam logic [MAG_W-1:0] RECIP_SQ [MAX_TERMS] = '{
        64'd0,
        64'd1099511627776, 64'd274877906944, 64'd122167958642, 64'd68719476736,
        64'd43980465111,   64'd30541989660,  64'd22439012812,  64'd17179869184,
        64'd13574217627,   64'd10995116278,  64'd9086872957,   64'd7635497415,
        64'd6505985963,    64'd5609753203,   64'd4886718346,   64'd4294967296,
        64'd3804538504,    64'd3393554407,   64'd3045738581
    };

    typedef logic [3:0][MAG_W-1:0] bj0s_pp_t;

    typedef struct packed {
        logic             sat;
        logic [MAG_W-1:0] mag;
    } bj0s_mag_t;

    typedef struct packed {
        logic                    sat;
        logic signed [MAG_W-1:0] val;
    } bj0s_sum_t;

    // Work carried down the pipeline for one argument
    typedef struct packed {
        logic [TERMS_W-1:0]      added;
        logic                    done;
        logic                    sat;
        logic signed [MAG_W-1:0] sum;
        logic [Q_W-1:0]          q;
        logic [MAG_W-1:0]        tmag;
        logic                    tsat;
        logic                    tneg;
        logic                    pend;
    } bj0s_pipe_t;

    // 32x32 partial products of a 64x64 unsigned multiply
    function automatic bj0s_pp_t bj0s_partials(input logic [MAG_W-1:0] a,
                                               input logic [MAG_W-1:0] b);
        bj0s_pp_t pp;
        pp[0] = {{HALF_W{1'b0}}, a[HALF_W-1:0]} * {{HALF_W{1'b0}}, b[HALF_W-1:0]};
        pp[1] = {{HALF_W{1'b0}}, a[HALF_W-1:0]} * {{HALF_W{1'b0}}, b[MAG_W-1:HALF_W]};
        pp[2] = {{HALF_W{1'b0}}, a[MAG_W-1:HALF_W]} * {{HALF_W{1'b0}}, b[HALF_W-1:0]};
        pp[3] = {{HALF_W{1'b0}}, a[MAG_W-1:HALF_W]} * {{HALF_W{1'b0}}, b[MAG_W-1:HALF_W]};
        return pp;
    endfunction

    // Sum the partials, take bits above the Q.40 point, saturate to 2^63-1
    function automatic bj0s_mag_t bj0s_combine(input bj0s_pp_t pp);
        logic [2*MAG_W-1:0] prod;
        bj0s_mag_t          r;
        prod = {{MAG_W{1'b0}}, pp[0]}
             + {{HALF_W{1'b0}}, pp[1], {HALF_W{1'b0}}}
             + {{HALF_W{1'b0}}, pp[2], {HALF_W{1'b0}}}
             + {pp[3], {MAG_W{1'b0}}};
        r.sat = |prod[2*MAG_W-1:MAG_W-1+FRAC_BITS];
        r.mag = r.sat ? MAG_MAX : {1'b0, prod[MAG_W-2+FRAC_BITS:FRAC_BITS]};
        return r;
    endfunction

    function automatic bj0s_sum_t bj0s_add_sat(input logic signed [MAG_W-1:0] s,
                                               input logic signed [MAG_W-1:0] t);
        logic signed [MAG_W:0] r;
        bj0s_sum_t             o;
        r = {s[MAG_W-1], s} + {t[MAG_W-1], t};
        o.sat = (r[MAG_W] != r[MAG_W-1]);
        if (o.sat) begin
            o.val = r[MAG_W] ? SUM_MIN : SUM_MAX;
        end else begin
            o.val = r[MAG_W-1:0];
        end
        return o;
    endfunction

    // Add the pending term to the sum and decide on the early stop
    function automatic bj0s_pipe_t bj0s_apply(input bj0s_pipe_t p,
                                              input logic [THR_W-1:0] thr);
        bj0s_pipe_t              o;
        bj0s_sum_t               s;
        logic signed [MAG_W-1:0] t;
        o = p;
        t = p.tneg ? -$signed(p.tmag) : $signed(p.tmag);
        s = bj0s_add_sat(p.sum, t);
        if (p.pend) begin
            o.sum   = s.val;
            o.sat   = p.sat | p.tsat | s.sat;
            o.added = p.added + 1'b1;
            o.done  = (p.tmag < {{(MAG_W-THR_W){1'b0}}, thr});
        end
        o.pend = 1'b0;
        return o;
    endfunction

endpackage

`default_nettype wire

@@ design/bj0s_square.sv @@
// Entry stage: magnitude of x and q = x*x/4 in Q13.40, series seeded with 1.
`default_nettype none

module bj0s_square (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic                      en,
    input  wire logic                      in_valid,
    input  wire logic [bj0s_pkg::X_W-1:0]  x_value,
    output bj0s_pkg::bj0s_pipe_t           out_pipe,
    output logic                           out_valid
);
    import bj0s_pkg::*;

    logic [X_W-1:0]     xmag;
    logic [2*X_W-1:0]   sq;
    bj0s_pipe_t         pipe_next;
    bj0s_pipe_t         pipe_reg;
    logic               valid_reg;

    always_comb begin
        xmag = x_value[X_W-1] ? X_W'(-x_value) : x_value;
        sq   = {{X_W{1'b0}}, xmag} * {{X_W{1'b0}}, xmag};
        pipe_next       = '0;
        pipe_next.sum   = ONE_Q40;
        pipe_next.tmag  = ONE_Q40;
        pipe_next.q     = sq[Q_W+9:10];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            pipe_reg <= pipe_next;
        end
    end

    assign out_pipe  = pipe_reg;
    assign out_valid = valid_reg;

endmodule

`default_nettype wire

@@ design/bj0s_term.sv @@
// One series term over four stages: add previous term, times q, times 1/k^2.
`default_nettype none

module bj0s_term (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          en,
    input  wire logic [bj0s_pkg::TERMS_W-1:0]  k_idx,
    input  wire logic [bj0s_pkg::THR_W-1:0]    thr,
    input  wire logic                          in_valid,
    input  wire bj0s_pkg::bj0s_pipe_t          in_pipe,
    output bj0s_pkg::bj0s_pipe_t               out_pipe,
    output logic                               out_valid
);
    import bj0s_pkg::*;

    logic [3:0]  valid_reg;
    bj0s_pipe_t  s1_pipe_reg, s2_pipe_reg, s3_pipe_reg, s4_pipe_reg;
    bj0s_pp_t    s1_pp_reg, s3_pp_reg;
    bj0s_pipe_t  s1_pipe_next, s2_pipe_next, s4_pipe_next;
    bj0s_mag_t   c2, c4;

    always_comb begin
        s1_pipe_next = bj0s_apply(in_pipe, thr);

        c2 = bj0s_combine(s1_pp_reg);
        s2_pipe_next      = s1_pipe_reg;
        s2_pipe_next.tmag = c2.mag;
        s2_pipe_next.tsat = c2.sat;

        c4 = bj0s_combine(s3_pp_reg);
        s4_pipe_next      = s3_pipe_reg;
        s4_pipe_next.tmag = c4.mag;
        s4_pipe_next.tsat = s3_pipe_reg.tsat | c4.sat;
        // odd k gives a negative term
        s4_pipe_next.tneg = k_idx[0];
        s4_pipe_next.pend = !s3_pipe_reg.done;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (en) begin
            valid_reg <= {valid_reg[2:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            s1_pipe_reg <= s1_pipe_next;
            s1_pp_reg   <= bj0s_partials(in_pipe.tmag, {{(MAG_W-Q_W){1'b0}}, in_pipe.q});
            s2_pipe_reg <= s2_pipe_next;
            s3_pipe_reg <= s2_pipe_reg;
            s3_pp_reg   <= bj0s_partials(s2_pipe_reg.tmag, RECIP_SQ[k_idx]);
            s4_pipe_reg <= s4_pipe_next;
        end
    end

    assign out_pipe  = s4_pipe_reg;
    assign out_valid = valid_reg[3];

endmodule

`default_nettype wire

@@ design/bj0s_round.sv @@
// Final stages: add the last term, round Q24.40 to Q8.24 and hold the result.
`default_nettype none

module bj0s_round (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          en,
    input  wire logic [bj0s_pkg::THR_W-1:0]    thr,
    input  wire logic                          in_valid,
    input  wire bj0s_pkg::bj0s_pipe_t          in_pipe,
    output logic                               out_valid,
    output logic [bj0s_pkg::X_W-1:0]           j0_value,
    output logic                               saturated,
    output logic [bj0s_pkg::TERMS_W-1:0]       terms_added
);
    import bj0s_pkg::*;

    logic [1:0]          valid_reg;
    bj0s_pipe_t          s1_pipe_reg;
    bj0s_sum_t           rs;
    logic [X_W-1:0]      j0_next, j0_reg;
    logic                sat_next, sat_reg;
    logic [TERMS_W-1:0]  added_reg;

    always_comb begin
        rs       = bj0s_add_sat(s1_pipe_reg.sum, RND_HALF);
        sat_next = s1_pipe_reg.sat | rs.sat;
        if (rs.val >= RES_HI) begin
            sat_next = 1'b1;
            j0_next  = RES_MAX;
        end else if (rs.val < RES_LO) begin
            sat_next = 1'b1;
            j0_next  = RES_MIN;
        end else begin
            j0_next  = rs.val[X_W+15:16];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (en) begin
            valid_reg <= {valid_reg[0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            s1_pipe_reg <= bj0s_apply(in_pipe, thr);
            j0_reg      <= j0_next;
            sat_reg     <= sat_next;
            added_reg   <= s1_pipe_reg.added;
        end
    end

    assign out_valid   = valid_reg[1];
    assign j0_value    = j0_reg;
    assign saturated   = sat_reg;
    assign terms_added = added_reg;

endmodule

`default_nettype wire

@@ design/bessel_j0_series.sv @@
// Top level: J0(x) power series evaluator, fully pipelined, one term per four stages.
//
//  Channel   Direction  Handshake            Content
//  s_        in         s_tvalid/s_tready    tdata[31:0] x_value (Q8.24)
//  m_        out        m_tvalid/m_tready    tdata j0_value, terms_added; tuser saturated
//  cfg_      in         cfg_wr_en            cfg_wr_data stop_threshold (Q.40)
//
//  The pipeline has one squaring stage, four stages per series term for
//  the 19 terms (two split 64x64 multiplies each), and two rounding stages.
//  One argument can enter every cycle unless a stalled result holds the pipeline.
//  Reset clears all valid bits and loads stop_threshold with 110.
//  A stalled result holds the whole pipeline, s_tready falls with it.
`default_nettype none

module bessel_j0_series (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    input  wire logic [31:0]                     s_tdata,   // [31:0] x_value
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    output logic [bj0s_pkg::OUT_TDATA_W-1:0]     m_tdata,   // [31:0] j0_value, [36:32] terms_added
    output logic                                 m_tuser,   // [0] saturated
    input  wire logic                            cfg_wr_en,
    input  wire logic [bj0s_pkg::THR_W-1:0]      cfg_wr_data
);
    import bj0s_pkg::*;

    logic                  en;
    logic [THR_W-1:0]      thr_reg;
    bj0s_pipe_t            pipe [MAX_TERMS];
    logic [MAX_TERMS-1:0]  pipe_valid;
    logic [X_W-1:0]        j0_value;
    logic                  saturated;
    logic [TERMS_W-1:0]    terms_added;

    // advance everything unless a result waits
    assign en       = !m_tvalid || m_tready;
    assign s_tready = en;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thr_reg <= THR_RESET;
        end else if (cfg_wr_en) begin
            thr_reg <= cfg_wr_data;
        end
    end

    bj0s_square u_square (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (s_tvalid),
        .x_value   (s_tdata[X_W-1:0]),
        .out_pipe  (pipe[0]),
        .out_valid (pipe_valid[0])
    );

    for (genvar k = 1; k < MAX_TERMS; k++) begin : g_term
        bj0s_term u_term (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .en        (en),
            .k_idx     (TERMS_W'(k)),
            .thr       (thr_reg),
            .in_valid  (pipe_valid[k-1]),
            .in_pipe   (pipe[k-1]),
            .out_pipe  (pipe[k]),
            .out_valid (pipe_valid[k])
        );
    end

    bj0s_round u_round (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .en          (en),
        .thr         (thr_reg),
        .in_valid    (pipe_valid[MAX_TERMS-1]),
        .in_pipe     (pipe[MAX_TERMS-1]),
        .out_valid   (m_tvalid),
        .j0_value    (j0_value),
        .saturated   (saturated),
        .terms_added (terms_added)
    );

    assign m_tdata = {{(OUT_TDATA_W-X_W-TERMS_W){1'b0}}, terms_added, j0_value};
    assign m_tuser = saturated;

endmodule

`default_nettype wire

@@ design/bj0s_checker.sv @@
// Port-level checks on the J0 series block, bound to the top level.
`default_nettype none

module bj0s_checker (
    input wire logic                              aclk,
    input wire logic                              aresetn,
    input wire logic                              s_tready,
    input wire logic                              m_tvalid,
    input wire logic                              m_tready,
    input wire logic [bj0s_pkg::OUT_TDATA_W-1:0]  m_tdata
);
    import bj0s_pkg::*;

    // a result held back must stay offered
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result dropped while stalled");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result offered right after reset");

    // a stalled output must stall the input side too
    a_backpressure: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |-> !s_tready)
        else $error("input taken while pipeline stalled");

    a_terms_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[X_W+TERMS_W-1:X_W] != '0)
                  && (m_tdata[X_W+TERMS_W-1:X_W] <= TERMS_W'(MAX_TERMS-1)))
        else $error("term count out of range");

endmodule

bind bessel_j0_series bj0s_checker u_bj0s_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire

@@ tb/bessel_j0_series_tb.sv @@
// Self-checking testbench for the J0 power series pipeline.
`default_nettype none

typedef struct {
    logic [31:0] x;
    logic [31:0] j0;
    logic        sat;
    logic [4:0]  terms;
} j0_expect_t;

class j0_scoreboard;
    logic [bj0s_pkg::THR_W-1:0] threshold;
    j0_expect_t                 pending[$];
    int                         fails;
    int                         checked;
    int                         sat_seen;
    int                         min_terms;
    int                         most_terms;

    function new();
        threshold  = 40'd110;
        fails      = 0;
        checked    = 0;
        sat_seen   = 0;
        min_terms  = 31;
        most_terms = 0;
    endfunction

    // (a*b) >> 40 truncated; bit 64 flags saturation to 2^63-1
    function logic [64:0] scale_q40(input logic [63:0] a, input logic [63:0] b);
        logic [127:0] prod;
        prod = {64'd0, a} * {64'd0, b};
        if (prod[127:103] != '0)
            return {1'b1, 64'h7FFF_FFFF_FFFF_FFFF};
        return {1'b0, prod[103:40]};
    endfunction

    function logic [63:0] inv_square(input int k);
        logic [63:0] k2;
        k2 = 64'(k) * 64'(k);
        return ((64'd1 << 40) + k2 / 2) / k2;
    endfunction

    // signed add clamped to the 64-bit range; bit 64 flags a clamp
    function logic [64:0] add_clamped(input logic signed [63:0] a,
                                      input logic signed [63:0] b);
        logic signed [64:0] r;
        r = {a[63], a} + {b[63], b};
        if (r[64] != r[63])
            return r[64] ? {1'b1, 64'h8000_0000_0000_0000} : {1'b1, 64'h7FFF_FFFF_FFFF_FFFF};
        return {1'b0, r[63:0]};
    endfunction

    function void note_input(input logic [31:0] x);
        j0_expect_t         e;
        logic [63:0]        xmag;
        logic [63:0]        q;
        logic [63:0]        mag;
        logic [64:0]        m;
        logic [64:0]        s;
        logic signed [63:0] sum;
        logic signed [63:0] t;
        logic signed [63:0] r;
        logic signed [63:0] shifted;
        bit                 sat;
        bit                 neg;
        int                 added;
        xmag  = x[31] ? {32'd0, -x} : {32'd0, x};
        q     = (xmag * xmag) >> 10;
        mag   = 64'd1 << 40;
        sum   = 64'sd1 <<< 40;
        sat   = 1'b0;
        neg   = 1'b0;
        added = 0;
        for (int k = 1; k < bj0s_pkg::MAX_TERMS; k++) begin
            m   = scale_q40(mag, q);
            sat = sat | m[64];
            m   = scale_q40(m[63:0], inv_square(k));
            sat = sat | m[64];
            mag = m[63:0];
            neg = !neg;
            t   = neg ? -$signed(mag) : $signed(mag);
            s   = add_clamped(sum, t);
            sat = sat | s[64];
            sum = s[63:0];
            added++;
            if (mag < {24'd0, threshold})
                break;
        end
        // round half up to Q8.24, clamp to 32 bits
        s   = add_clamped(sum, 64'sd32768);
        sat = sat | s[64];
        r   = s[63:0];
        if (r >= 64'sh0000_8000_0000_0000) begin
            sat  = 1'b1;
            e.j0 = 32'h7FFF_FFFF;
        end else if (r < 64'shFFFF_8000_0000_0000) begin
            sat  = 1'b1;
            e.j0 = 32'h8000_0000;
        end else begin
            shifted = r >>> 16;
            e.j0    = shifted[31:0];
        end
        e.x     = x;
        e.sat   = sat;
        e.terms = 5'(added);
        if (sat) sat_seen++;
        if (added < min_terms) min_terms = added;
        if (added > most_terms) most_terms = added;
        pending.push_back(e);
    endfunction

    task report(input string msg);
        fails++;
        if (fails <= 30)
            $display("mismatch: %s", msg);
    endtask

    task check_result(input logic [31:0] j0, input logic sat, input logic [4:0] terms);
        j0_expect_t e;
        if (pending.size() == 0) begin
            report($sformatf("j0=%h sat=%b terms=%0d with nothing outstanding", j0, sat, terms));
            return;
        end
        e = pending.pop_front();
        checked++;
        if (j0 !== e.j0)
            report($sformatf("x=%h j0 %h, want %h", e.x, j0, e.j0));
        if (sat !== e.sat)
            report($sformatf("x=%h saturated %b, want %b", e.x, sat, e.sat));
        if (terms !== e.terms)
            report($sformatf("x=%h terms_added %0d, want %0d", e.x, terms, e.terms));
    endtask
endclass

module bessel_j0_series_tb;
    localparam int PHASES      = 6;
    localparam int RAND_ITEMS  = 100;
    localparam int HOLD_CYCLES = 250;
    localparam int N_CORNERS   = 19;

    logic        aclk        = 1'b0;
    logic        aresetn     = 1'b0;
    logic        s_tvalid    = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata     = '0;
    logic        m_tvalid;
    logic        m_tready    = 1'b0;
    logic [bj0s_pkg::OUT_TDATA_W-1:0] m_tdata;
    logic        m_tuser;
    logic        cfg_wr_en   = 1'b0;
    logic [bj0s_pkg::THR_W-1:0] cfg_wr_data = '0;

    int          src_idle_pct  = 28;
    int          sink_idle_pct = 28;
    logic        hold_arm      = 1'b0;
    logic        hold_used     = 1'b0;
    int          hold_left     = 0;
    int          sent          = 0;

    j0_scoreboard sb;

    bessel_j0_series i_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    always #5 aclk = ~aclk;

    // Receiver: random stalls, plus one long hold-off to back up the pipeline
    always @(posedge aclk) begin
        if (hold_arm && !hold_used) begin
            hold_used <= 1'b1;
            hold_left <= HOLD_CYCLES;
            m_tready  <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end else begin
            m_tready  <= ($urandom_range(99) >= sink_idle_pct);
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            sb.check_result(m_tdata[31:0], m_tuser, m_tdata[36:32]);
    end

    task automatic send_x(input logic [31:0] x);
        while ($urandom_range(99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= x;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sb.note_input(x);
        sent++;
    endtask

    task automatic write_threshold(input logic [bj0s_pkg::THR_W-1:0] v);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        sb.threshold = v;
        @(posedge aclk);
    endtask

    task automatic wait_drained();
        while (sb.pending.size() != 0) @(posedge aclk);
    endtask

    // Mostly arguments the series can handle, some across the full range
    function automatic logic [31:0] pick_x();
        logic [31:0] m;
        int          sel;
        sel = $urandom_range(99);
        if (sel < 55)
            m = $urandom_range(32'h0600_0000);
        else if (sel < 80)
            m = $urandom_range(32'h1000_0000);
        else
            return $urandom();
        return $urandom_range(1) ? -m : m;
    endfunction

    initial begin
        logic [bj0s_pkg::THR_W-1:0] plan [PHASES];
        logic [31:0]                corners [N_CORNERS];
        sb = new();
        corners = '{
            32'h0000_0000, 32'h0000_0001, 32'hFFFF_FFFF, 32'h0000_8000,
            32'h0100_0000, 32'hFF00_0000, 32'd40346280,  32'd92611547,
            32'h0400_0000, 32'h0A00_0000, 32'hF000_0000, 32'h1400_0000,
            32'h2000_0000, 32'hC000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
            32'h5555_5555, 32'hAAAA_AAAA, 32'h0200_0000
        };
        plan[0] = 40'd110;
        plan[1] = '0;
        plan[2] = '1;
        plan[3] = 40'($urandom_range(1, 32'h0100_0000));
        plan[4] = {8'($urandom_range(255)), 32'($urandom())};
        plan[5] = 40'd1 << $urandom_range(8, 36);

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (int p = 0; p < PHASES; p++) begin
            // phase 0 runs on the threshold loaded by reset
            if (p != 0)
                write_threshold(plan[p]);
            src_idle_pct  <= (p == 1) ? 0 : 28;
            sink_idle_pct <= (p == 1) ? 0 : 28;
            if (p <= 2) begin
                for (int i = 0; i < N_CORNERS; i++)
                    send_x(corners[i]);
            end
            for (int n = 0; n < RAND_ITEMS; n++) begin
                send_x(pick_x());
                if (p == 2 && n == 10)
                    hold_arm <= 1'b1;
            end
            s_tvalid <= 1'b0;
            wait_drained();
        end

        repeat (100) @(posedge aclk);
        $display("checked %0d of %0d arguments over %0d threshold settings",
                 sb.checked, sent, PHASES);
        $display("%0d saturated results, %0d to %0d terms added per argument",
                 sb.sat_seen, sb.min_terms, sb.most_terms);
        if (sb.fails == 0 && sb.pending.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    initial begin
        #3_000_000;
        $display("timeout with %0d results outstanding", sb.pending.size());
        $display("status: fail");
        $finish;
    end
endmodule

`default_nettype wire

@@ files.f @@
design/bj0s_pkg.sv
design/bj0s_square.sv
design/bj0s_term.sv
design/bj0s_round.sv
design/bessel_j0_series.sv
design/bj0s_checker.sv
tb/bessel_j0_series_tb.sv
